>>> hdl/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define IPE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// next-cycle implication, off during reset
`define IPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

// same-cycle implication, live through reset
`define IPE_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

`endif

>>> hdl/ipe_pkg.sv
// Package: types and constants of the icon pixel expander
`timescale 1ns / 1ps
`default_nettype none

package ipe_pkg;

  localparam int MAX_WIDTH       = 256;
  localparam int PAL_DEPTH_DEF   = 256;
  localparam int ROW_CAP         = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int WIDTH_W         = 9;
  localparam int COL_W           = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 9;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [1:0] {
    OP_PIXEL     = 2'd0,
    OP_PAL_WRITE = 2'd1,
    OP_MASK_LOAD = 2'd2,
    OP_NONE      = 2'd3
  } ipe_op_t;

  typedef enum logic [1:0] {
    MODE_PASS     = 2'd0,
    MODE_RGB_MASK = 2'd1,
    MODE_PAL8     = 2'd2,
    MODE_PAL4     = 2'd3
  } ipe_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_MASK_EN  = 2'd2,
    REG_MASK_SET = 2'd3
  } ipe_reg_t;

  typedef struct packed {
    ipe_mode_t            mode;
    logic [WIDTH_W-1:0]   width;
    logic                 mask_en;
    logic                 mask_set;
  } ipe_cfg_t;

  typedef struct packed {
    logic         valid;
    logic [31:0]  data;
    logic [7:0]   mask;
  } ipe_item_t;

endpackage

`default_nettype wire

>>> hdl/ipe_if.sv
// Channel interfaces: input request channel and result channel
`timescale 1ns / 1ps
`default_nettype none

interface ipe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] pixel_data;
  logic [7:0]  mask_byte;
  logic [7:0]  palette_index;
  logic [7:0]  palette_red;
  logic [7:0]  palette_green;
  logic [7:0]  palette_blue;

  modport source (
    output valid, op, pixel_data, mask_byte, palette_index,
           palette_red, palette_green, palette_blue,
    input  ready
  );
  modport sink (
    input  valid, op, pixel_data, mask_byte, palette_index,
           palette_red, palette_green, palette_blue,
    output ready
  );
endinterface

interface ipe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb;
  logic        row_end;
  logic        last;

  modport source (output valid, argb, row_end, last, input ready);
  modport sink (input valid, argb, row_end, last, output ready);
endinterface

`default_nettype wire

>>> hdl/ipe_lane.sv
// Palette lane: one palette copy with a registered read port
`timescale 1ns / 1ps
`default_nettype none

module ipe_lane #(
  parameter int PALETTE_DEPTH = ipe_pkg::PAL_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [7:0]  wr_index,
  input  wire logic [23:0] wr_color,
  input  wire logic        rd_en,
  input  wire logic [7:0]  rd_index,
  output      logic [23:0] rd_color
);
  import ipe_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] mem [PALETTE_DEPTH];
  logic [23:0] rd_q;
  logic        rd_ok;
  logic        wr_in_range;
  logic        rd_in_range;

  assign wr_in_range = ({1'b0, wr_index} < 9'(PALETTE_DEPTH));
  assign rd_in_range = ({1'b0, rd_index} < 9'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_index[AW-1:0]] <= wr_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_index[AW-1:0]];
      rd_ok <= rd_in_range;
    end
  end

  assign rd_color = rd_ok ? rd_q : 24'h000000;

endmodule

`default_nettype wire

>>> hdl/ipe_merge.sv
// Merge stage: orders lane colors into pixels, tracks column and mask alpha
`timescale 1ns / 1ps
`default_nettype none

module ipe_merge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ipe_pkg::ipe_cfg_t  cfg,
  input  wire ipe_pkg::ipe_item_t item,
  input  wire logic [23:0]        color0,
  input  wire logic [23:0]        color1,
  output      logic               release_item,
  ipe_out_if.source               results
);
  import ipe_pkg::*;

  logic               phase;
  logic               phase_next;
  logic [COL_W-1:0]   column;
  logic [COL_W-1:0]   column_next;
  logic               out_valid;
  logic [31:0]        out_argb;
  logic               out_row_end;
  logic               out_last;

  logic               load_ok;
  logic               beat;
  logic [WIDTH_W-1:0] row_lim;
  logic               end_row;
  logic               mask_bit;
  logic [7:0]         alpha;
  logic               beat_last;
  logic [31:0]        beat_argb;

  assign load_ok = !out_valid || results.ready;
  assign beat    = item.valid && load_ok;

  always_comb begin
    if (cfg.width == '0 || cfg.width > WIDTH_W'(ROW_CAP)) begin
      row_lim = WIDTH_W'(ROW_CAP);
    end else begin
      row_lim = cfg.width;
    end
  end

  assign end_row  = ({1'b0, column} + WIDTH_W'(1)) >= row_lim;
  assign mask_bit = item.mask[3'd7 - column[2:0]];
  assign alpha    = (cfg.mask_en && (mask_bit == cfg.mask_set)) ? ALPHA_CLEAR : ALPHA_OPAQUE;

  always_comb begin
    case (cfg.mode)
      MODE_PASS:     beat_argb = item.data;
      MODE_RGB_MASK: beat_argb = {alpha, item.data[23:0]};
      MODE_PAL8:     beat_argb = {alpha, color0};
      default:       beat_argb = {alpha, phase ? color1 : color0};
    endcase
  end

  // high nibble ends its item only at a row end
  assign beat_last    = !(cfg.mode == MODE_PAL4 && !phase && !end_row);
  assign release_item = beat && beat_last;

  always_comb begin
    phase_next  = phase;
    column_next = column;
    if (beat) begin
      phase_next  = !beat_last;
      column_next = end_row ? '0 : column + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      column    <= '0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      column    <= column_next;
      out_valid <= beat || (out_valid && !results.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      out_argb    <= beat_argb;
      out_row_end <= end_row;
      out_last    <= beat_last;
    end
  end

  assign results.valid   = out_valid;
  assign results.argb    = out_argb;
  assign results.row_end = out_row_end;
  assign results.last    = out_last;

endmodule

`default_nettype wire

>>> hdl/icon_pixel_expander_top.sv
// Top level of the icon pixel expander
//
//  channel   dir  handshake      payload
//  items     in   valid/ready    op, pixel_data, mask_byte, palette_index/red/green/blue
//  results   out  valid/ready    argb, row_end, last
//  cfg       in   cfg_we         cfg_index, cfg_data
//
// Modes 0-2 take one request per cycle while the output is not stalled; mode 3 holds a request
// until both nibbles have gone out, or only the high nibble when that ends the row.
// A pixel passes the palette read register, then the output register.
// Palette writes and mask loads finish on acceptance and give no result.
// rst sets config to its defaults and clears mask, column and valids; palette contents stay undefined until written.
// A stalled output holds the pending item, and items.ready drops once it is occupied.
`timescale 1ns / 1ps
`default_nettype none

module icon_pixel_expander_top #(
  parameter int PALETTE_DEPTH = ipe_pkg::PAL_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ipe_in_if.sink                              items,
  ipe_out_if.source                           results,
  input  wire logic                           cfg_we,
  input  wire logic [ipe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipe_pkg::*;

  ipe_cfg_t    cfg;
  logic [7:0]  mask_bits;
  ipe_item_t   held;
  logic        accept;
  logic        pix_accept;
  logic        pal_write;
  logic        release_item;
  logic [7:0]  rd_index0;
  logic [7:0]  rd_index1;
  logic [23:0] wr_color;
  logic [23:0] color0;
  logic [23:0] color1;

  assign items.ready = !held.valid || release_item;
  assign accept      = items.valid && items.ready;
  assign pix_accept  = accept && (items.op == OP_PIXEL);
  assign pal_write   = accept && (items.op == OP_PAL_WRITE);
  assign wr_color    = {items.palette_red, items.palette_green, items.palette_blue};

  assign rd_index0 = (cfg.mode == MODE_PAL4) ? {4'h0, items.pixel_data[7:4]}
                                             : items.pixel_data[7:0];
  assign rd_index1 = {4'h0, items.pixel_data[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_PASS;
      cfg.width    <= WIDTH_W'(32);
      cfg.mask_en  <= 1'b1;
      cfg.mask_set <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     cfg.mode     <= ipe_mode_t'(cfg_data[1:0]);
        REG_WIDTH:    cfg.width    <= cfg_data[WIDTH_W-1:0];
        REG_MASK_EN:  cfg.mask_en  <= cfg_data[0];
        REG_MASK_SET: cfg.mask_set <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_bits <= '0;
    end else if (accept && items.op == OP_MASK_LOAD) begin
      mask_bits <= items.mask_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (pix_accept) begin
      held.valid <= 1'b1;
    end else if (release_item) begin
      held.valid <= 1'b0;
    end
    if (pix_accept) begin
      held.data <= items.pixel_data;
      held.mask <= mask_bits;
    end
  end

  ipe_lane #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_lane0 (
    .clk      (clk),
    .wr_en    (pal_write),
    .wr_index (items.palette_index),
    .wr_color (wr_color),
    .rd_en    (pix_accept),
    .rd_index (rd_index0),
    .rd_color (color0)
  );

  ipe_lane #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_lane1 (
    .clk      (clk),
    .wr_en    (pal_write),
    .wr_index (items.palette_index),
    .wr_color (wr_color),
    .rd_en    (pix_accept),
    .rd_index (rd_index1),
    .rd_color (color1)
  );

  ipe_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (held),
    .color0       (color0),
    .color1       (color1),
    .release_item (release_item),
    .results      (results)
  );

endmodule

`default_nettype wire

>>> hdl/ipe_checker.sv
// Port checker for the icon pixel expander, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ipe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_argb,
  input wire logic        out_row_end,
  input wire logic        out_last
);

  `IPE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_argb) && $stable(out_last))
  `IPE_ASSERT_SAME(a_pair_mid_row, out_valid && !out_last, !out_row_end)
  `IPE_ASSERT_NEXT(a_pair_next, out_valid && out_ready && !out_last, out_valid && out_last)
  `IPE_ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid)

endmodule

bind icon_pixel_expander_top ipe_checker u_ipe_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_argb    (results.argb),
  .out_row_end (results.row_end),
  .out_last    (results.last)
);

`default_nettype wire

>>> bench/testbench.sv
// Testbench: icon pixel expander, directed corner requests then randomized traffic
`timescale 1ns / 1ps

module testbench;
  import ipe_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    ipe_op_t     op;
    logic [31:0] data;
    logic [7:0]  mask;
    logic [7:0]  pidx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } req_t;

  typedef struct packed {
    logic [31:0] argb;
    logic        row_done;
    logic        item_done;
  } pixel_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ipe_in_if  req_ch ();
  ipe_out_if pix_ch ();

  icon_pixel_expander_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (req_ch),
    .results   (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // expected pixels and the predictor's copy of the block state
  pixel_t pending_pixels[$];
  logic [23:0] pal_copy [256];
  logic [7:0] mask_copy;
  logic [7:0] col_copy;
  ipe_mode_t mode_copy;
  logic [WIDTH_W-1:0] width_copy;
  logic mask_en_copy;
  logic mask_set_copy;

  int gap_pct;
  int stall_pct;
  int fail_count;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pix_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      pix_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic note_fail(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        note_fail($sformatf("unexpected pixel argb %08h", pix_ch.argb));
      end else begin
        want = pending_pixels.pop_front();
        if (pix_ch.argb !== want.argb || pix_ch.row_end !== want.row_done ||
            pix_ch.last !== want.item_done)
          note_fail($sformatf("argb exp %08h got %08h, row_end exp %0b got %0b, last exp %0b got %0b",
                              want.argb, pix_ch.argb, want.row_done, pix_ch.row_end,
                              want.item_done, pix_ch.last));
      end
    end
  end

  function automatic logic [7:0] alpha_now();
    logic mbit;
    if (!mask_en_copy) return ALPHA_OPAQUE;
    mbit = mask_copy[3'd7 - col_copy[2:0]];
    if (mask_set_copy) return mbit ? ALPHA_CLEAR : ALPHA_OPAQUE;
    return mbit ? ALPHA_OPAQUE : ALPHA_CLEAR;
  endfunction

  function automatic bit row_ends();
    int lim;
    lim = (width_copy == 0 || width_copy > ROW_CAP) ? ROW_CAP : int'(width_copy);
    return (int'(col_copy) + 1 >= lim);
  endfunction

  function automatic void push_pixel(input logic [31:0] argb, input bit item_done);
    pixel_t px;
    bit ends;
    ends = row_ends();
    px.argb = argb;
    px.row_done = ends;
    px.item_done = item_done;
    pending_pixels.push_back(px);
    col_copy = ends ? 8'd0 : col_copy + 8'd1;
  endfunction

  function automatic void expand_request(input req_t r);
    bit ends;
    case (r.op)
      OP_PAL_WRITE: pal_copy[r.pidx] = {r.red, r.green, r.blue};
      OP_MASK_LOAD: mask_copy = r.mask;
      OP_PIXEL: begin
        case (mode_copy)
          MODE_PASS: push_pixel(r.data, 1'b1);
          MODE_RGB_MASK: push_pixel({alpha_now(), r.data[23:0]}, 1'b1);
          MODE_PAL8: push_pixel({alpha_now(), pal_copy[r.data[7:0]]}, 1'b1);
          default: begin
            ends = row_ends();
            push_pixel({alpha_now(), pal_copy[{4'd0, r.data[7:4]}]}, ends);
            // odd width: low nibble is padding when the high one ends the row
            if (!ends) push_pixel({alpha_now(), pal_copy[{4'd0, r.data[3:0]}]}, 1'b1);
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic req_t rand_req(input ipe_op_t op);
    req_t r;
    r.op = op;
    r.data = $urandom;
    r.mask = 8'($urandom);
    r.pidx = 8'($urandom);
    r.red = 8'($urandom);
    r.green = 8'($urandom);
    r.blue = 8'($urandom);
    return r;
  endfunction

  task automatic send_req(input req_t r);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op = r.op;
    req_ch.pixel_data = r.data;
    req_ch.mask_byte = r.mask;
    req_ch.palette_index = r.pidx;
    req_ch.palette_red = r.red;
    req_ch.palette_green = r.green;
    req_ch.palette_blue = r.blue;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expand_request(r);
  endtask

  task automatic send_pixel(input logic [31:0] data);
    req_t r;
    r = rand_req(OP_PIXEL);
    r.data = data;
    send_req(r);
  endtask

  task automatic send_mask(input logic [7:0] mask);
    req_t r;
    r = rand_req(OP_MASK_LOAD);
    r.mask = mask;
    send_req(r);
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ipe_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_MODE:     mode_copy = ipe_mode_t'(val[1:0]);
      REG_WIDTH:    width_copy = val;
      REG_MASK_EN:  mask_en_copy = val[0];
      REG_MASK_SET: mask_set_copy = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // every entry gets written so no pixel ever reads an unwritten one
  task automatic test_palette_fill();
    req_t r;
    for (int i = 0; i < 256; i++) begin
      r = rand_req(OP_PAL_WRITE);
      r.pidx = 8'(i);
      if (i == 0) {r.red, r.green, r.blue} = 24'h000000;
      if (i == 255) {r.red, r.green, r.blue} = 24'hFFFFFF;
      send_req(r);
    end
    drain_pixels();
  endtask

  task automatic test_pass_modes();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_req(rand_req(OP_NONE));
    drain_pixels();
    write_reg(REG_MODE, 9'(MODE_RGB_MASK));
    send_mask(8'hA5);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h80FF_7F01);
    drain_pixels();
    write_reg(REG_MASK_SET, 9'd0);
    send_pixel(32'h0000_0000);
    send_pixel(32'h7F12_3456);
    drain_pixels();
    write_reg(REG_MASK_EN, 9'd0);
    send_pixel(32'h00AB_CDEF);
    drain_pixels();
  endtask

  task automatic test_palette_modes();
    write_reg(REG_MASK_EN, 9'd1);
    write_reg(REG_MODE, 9'(MODE_PAL8));
    send_mask(8'hFF);
    send_pixel(32'hFFFF_FF00);
    send_pixel(32'h0000_00FF);
    drain_pixels();
    write_reg(REG_MODE, 9'(MODE_PAL4));
    write_reg(REG_WIDTH, 9'd3);
    send_pixel(32'h0000_00F0);
    send_pixel(32'hFFFF_FF0F);
    send_pixel(32'h0000_005A);
    drain_pixels();
  endtask

  task automatic test_width_edges();
    write_reg(REG_MODE, 9'(MODE_PASS));
    write_reg(REG_WIDTH, 9'd1);
    send_pixel($urandom);
    send_pixel($urandom);
    drain_pixels();
    write_reg(REG_WIDTH, 9'd0);
    send_pixel($urandom);
    send_pixel($urandom);
    drain_pixels();
    write_reg(REG_WIDTH, 9'd511);
    send_pixel($urandom);
    send_pixel($urandom);
    drain_pixels();
    // column already past the new width
    write_reg(REG_WIDTH, 9'd2);
    send_pixel($urandom);
    drain_pixels();
    // reach column 7 so the two nibbles of one item read mask bits 0 and 7 of the same byte
    write_reg(REG_WIDTH, 9'd32);
    write_reg(REG_MODE, 9'(MODE_PAL4));
    send_mask(8'h01);
    repeat (3) send_pixel($urandom);
    drain_pixels();
    write_reg(REG_MODE, 9'(MODE_PAL8));
    send_pixel($urandom);
    drain_pixels();
    write_reg(REG_MODE, 9'(MODE_PAL4));
    send_pixel($urandom);
    drain_pixels();
  endtask

  function automatic req_t random_req();
    int pick;
    pick = $urandom_range(99);
    if (pick < 74) return rand_req(OP_PIXEL);
    if (pick < 88) return rand_req(OP_MASK_LOAD);
    if (pick < 97) return rand_req(OP_PAL_WRITE);
    return rand_req(OP_NONE);
  endfunction

  task automatic test_random_traffic();
    int gaps [4] = '{0, 87, 0, 18};
    int stalls [4] = '{0, 0, 87, 18};
    logic [CFG_DATA_W-1:0] w;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      for (int seg = 0; seg < 3; seg++) begin
        drain_pixels();
        case ($urandom_range(9))
          0: w = 9'd1;
          1: w = 9'd256;
          2: w = 9'd0;
          3: w = 9'd511;
          default: w = 9'($urandom_range(24, 1));
        endcase
        write_reg(REG_MODE, 9'($urandom_range(3)));
        write_reg(REG_WIDTH, w);
        write_reg(REG_MASK_EN, 9'($urandom_range(1)));
        write_reg(REG_MASK_SET, 9'($urandom_range(1)));
        repeat (22) send_req(random_req());
      end
    end
    drain_pixels();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_PIXEL;
    req_ch.pixel_data = '0;
    req_ch.mask_byte = '0;
    req_ch.palette_index = '0;
    req_ch.palette_red = '0;
    req_ch.palette_green = '0;
    req_ch.palette_blue = '0;
    gap_pct = 0;
    stall_pct = 0;
    fail_count = 0;
    cycles = 0;
    mode_copy = MODE_PASS;
    width_copy = 9'd32;
    mask_en_copy = 1'b1;
    mask_set_copy = 1'b1;
    mask_copy = 8'd0;
    col_copy = 8'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_palette_fill();
    test_pass_modes();
    test_palette_modes();
    test_width_edges();
    test_random_traffic();

    drain_pixels();
    if (pending_pixels.size() != 0)
      note_fail($sformatf("%0d pixels never arrived", pending_pixels.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
